[rtl/swhsr_pkg.sv]
// Shared constants and types for the single-wire humidity sensor reader.
package swhsr_pkg;

  localparam int unsigned FRAME_BITS = 40;
  localparam int unsigned BIT_CNT_W  = $clog2(FRAME_BITS + 1);
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned BYTE_W     = 8;

  // Byte positions within the received frame (byte 0 arrives first)
  localparam int unsigned HUM_LSB  = FRAME_BITS - BYTE_W;
  localparam int unsigned TEMP_LSB = FRAME_BITS - 3 * BYTE_W;
  localparam int unsigned SUM_LSB  = 0;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TIMEOUT = 2'd3;

  localparam logic [TICK_W-1:0] START_LOW_RST    = 16'd18000;
  localparam logic [BYTE_W-1:0] RELEASE_HIGH_RST = 8'd40;
  localparam logic [BYTE_W-1:0] ONE_THRESH_RST   = 8'd40;
  localparam logic [TICK_W-1:0] WAIT_TIMEOUT_RST = 16'd10000;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    logic               [BYTE_W-1:0] temperature;
    logic               [BYTE_W-1:0] humidity;
    logic                            status;
    logic                            done_res;
    logic                            busy_res;
    logic                            drive_level;
    logic                            drive_enable;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

[rtl/swhsr_core.sv]
// Sequencer for the sensor transaction: line drive, response waits and bit decode.
module swhsr_core import swhsr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    step_i,
  input  logic    start_request_i,
  input  logic    line_level_i,
  output result_t result_o
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LOW     = 3'd1,
    PH_HIGH    = 3'd2,
    PH_RESP_HI = 3'd3,
    PH_RESP_LO = 3'd4,
    PH_BIT_HI  = 3'd5,
    PH_MEASURE = 3'd6
  } phase_e;

  logic [TICK_W-1:0] start_low_q, wait_timeout_q;
  logic [BYTE_W-1:0] release_high_q, one_thresh_q;

  phase_e                phase_q, phase_d;
  logic [TICK_W-1:0]     tick_q, tick_d;
  logic [BIT_CNT_W-1:0]  bit_q, bit_d;
  logic [FRAME_BITS-1:0] shift_q, shift_d;
  logic [BYTE_W-1:0]     hum_q, hum_d;
  logic [BYTE_W-1:0]     temp_q, temp_d;
  logic                  ldh_q, ldh_d;

  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W:0]   pulse_len;
  logic              want_lvl, match, timeout, done, err, bit_val, idle;
  logic [BYTE_W:0]   byte_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q    <= START_LOW_RST;
      release_high_q <= RELEASE_HIGH_RST;
      one_thresh_q   <= ONE_THRESH_RST;
      wait_timeout_q <= WAIT_TIMEOUT_RST;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_START_LOW:    start_low_q    <= cfg_i.data;
        CFG_RELEASE_HIGH: release_high_q <= cfg_i.data[BYTE_W-1:0];
        CFG_ONE_THRESH:   one_thresh_q   <= cfg_i.data[BYTE_W-1:0];
        CFG_WAIT_TIMEOUT: wait_timeout_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign tick_inc  = tick_q + 1'b1;
  assign pulse_len = {1'b0, tick_q} + 1'b1;
  assign want_lvl  = !(phase_q == PH_RESP_LO || phase_q == PH_MEASURE);
  assign match     = (line_level_i == want_lvl);
  assign timeout   = (tick_q >= wait_timeout_q);
  assign bit_val   = (pulse_len > {{(TICK_W + 1 - BYTE_W){1'b0}}, one_thresh_q});

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    hum_d    = hum_q;
    temp_d   = temp_q;
    ldh_d    = ldh_q;
    done     = 1'b0;
    err      = 1'b0;
    byte_sum = '0;

    unique case (phase_q)
      PH_LOW: begin
        tick_d = tick_inc;
        if (tick_inc >= start_low_q) begin
          phase_d = PH_HIGH;
          tick_d  = '0;
        end
      end
      PH_HIGH: begin
        tick_d = tick_inc;
        if (tick_inc >= {{(TICK_W - BYTE_W){1'b0}}, release_high_q}) begin
          phase_d = PH_RESP_HI;
          tick_d  = '0;
        end
      end
      PH_RESP_HI, PH_RESP_LO, PH_BIT_HI: begin
        if (match) begin
          tick_d = '0;
          unique case (phase_q)
            PH_RESP_HI: phase_d = PH_RESP_LO;
            PH_RESP_LO: phase_d = PH_BIT_HI;
            default:    phase_d = PH_MEASURE;
          endcase
        end else if (timeout) begin
          done = 1'b1;
          err  = 1'b1;
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_MEASURE: begin
        if (match) begin
          shift_d = {shift_q[FRAME_BITS-2:0], bit_val};
          bit_d   = bit_q + 1'b1;
          tick_d  = '0;
          if (bit_d >= BIT_CNT_W'(FRAME_BITS)) begin
            hum_d    = shift_d[HUM_LSB +: BYTE_W];
            temp_d   = shift_d[TEMP_LSB +: BYTE_W];
            byte_sum = {1'b0, hum_d} + {1'b0, temp_d};
            done     = 1'b1;
            if ({1'b0, shift_d[SUM_LSB +: BYTE_W]} != byte_sum) err = 1'b1;
            else ldh_d = 1'b1;
          end else begin
            phase_d = PH_BIT_HI;
          end
        end else if (timeout) begin
          done = 1'b1;
          err  = 1'b1;
        end else begin
          tick_d = tick_inc;
        end
      end
      default: begin
        // idle, and the unused code falls back to idle
        phase_d = PH_IDLE;
        if (start_request_i) begin
          phase_d = PH_LOW;
          tick_d  = '0;
          bit_d   = '0;
          shift_d = '0;
          ldh_d   = 1'b0;
        end
      end
    endcase

    if (done) begin
      phase_d = PH_IDLE;
      tick_d  = '0;
      if (err) ldh_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      hum_q   <= '0;
      temp_q  <= '0;
      ldh_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      hum_q   <= hum_d;
      temp_q  <= temp_d;
      ldh_q   <= ldh_d;
    end
  end

  // Result reflects the state after this tick
  assign idle = (phase_d == PH_IDLE);
  assign result_o.drive_enable = (phase_d == PH_LOW) || (phase_d == PH_HIGH) || (idle && ldh_d);
  assign result_o.drive_level  = (phase_d == PH_HIGH) || (idle && ldh_d);
  assign result_o.busy_res     = !idle;
  assign result_o.done_res     = done;
  assign result_o.status       = done & err;
  assign result_o.humidity     = hum_d;
  assign result_o.temperature  = temp_d;

endmodule

[rtl/single_wire_humidity_sensor_reader.sv]
// Top level: tick stream in, one status/result transaction out per tick.
// The result of an accepted tick is registered and shown on the master side in the next cycle.
// Throughput: one tick per cycle; the output register takes a new result
// whenever it is empty or being drained.
// Reset: asynchronous, active low; registers return to defaults, sequencer idle,
// latched readings zero, output register empty.
module single_wire_humidity_sensor_reader import swhsr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [0] start_request, [1] line_level, [7:2] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] drive_enable, [1] drive_level, [2] busy_res, [3] done_res, [4] status,
  // [12:5] humidity, [20:13] temperature, [23:21] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned RES_W = $bits(result_t);

  cfg_wr_t cfg;
  result_t result;
  logic    accept;
  logic    out_valid_q;
  result_t out_q;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  swhsr_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .step_i          (accept),
    .start_request_i (s_axis_tdata[0]),
    .line_level_i    (s_axis_tdata[1]),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, out_q};

endmodule

[tb/testbench.sv]
// Testbench for the single-wire humidity sensor reader: reactive sensor frames, checked per tick.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swhsr_pkg::*;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_PULL_LOW,
    SEQ_PULL_HIGH,
    SEQ_ACK_HIGH,
    SEQ_ACK_LOW,
    SEQ_BIT_WAIT,
    SEQ_BIT_TIME
  } seq_e;

  // how the sensor side of one reading behaves
  typedef enum int {
    SHAPE_FRAME,
    SHAPE_STALL,
    SHAPE_NOISE
  } shape_e;

  // where a stalled reading stops answering
  typedef enum int {
    STALL_NONE = -1,
    STALL_ACK_HIGH,
    STALL_ACK_LOW,
    STALL_BIT_GAP,
    STALL_BIT_PULSE
  } stall_e;

  class reader_tracker;
    logic [TICK_W-1:0]      low_len;
    logic [BYTE_W-1:0]      high_len;
    logic [BYTE_W-1:0]      one_limit;
    logic [TICK_W-1:0]      wait_limit;
    seq_e                   seq;
    logic [TICK_W-1:0]      elapsed;
    logic [BIT_CNT_W-1:0]   bits_taken;
    logic [FRAME_BITS-1:0]  frame_bits;
    logic [BYTE_W-1:0]      hum_q;
    logic [BYTE_W-1:0]      temp_q;
    bit                     hold_high;
    result_t                due_results[$];
    int                     failures;

    function new();
      low_len    = 16'd18000;
      high_len   = 8'd40;
      one_limit  = 8'd40;
      wait_limit = 16'd10000;
      seq        = SEQ_IDLE;
      elapsed    = '0;
      bits_taken = '0;
      frame_bits = '0;
      hum_q      = '0;
      temp_q     = '0;
      hold_high  = 1'b0;
      failures   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_START_LOW:    low_len = data;
        CFG_RELEASE_HIGH: high_len = data[BYTE_W-1:0];
        CFG_ONE_THRESH:   one_limit = data[BYTE_W-1:0];
        CFG_WAIT_TIMEOUT: wait_limit = data;
        default: ;
      endcase
    endfunction

    function bit busy();
      return seq != SEQ_IDLE;
    endfunction

    // sensor is expected to be talking
    function bit answering();
      return seq >= SEQ_ACK_HIGH;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // one tick through the sequencer, queue what the block should report
    function void advance_tick(bit start, bit line);
      bit                finished;
      bit                failed;
      bit                want;
      logic [TICK_W:0]   pulse;
      logic [BYTE_W:0]   byte_sum;
      result_t           r;
      finished = 1'b0;
      failed   = 1'b0;
      case (seq)
        SEQ_PULL_LOW: begin
          elapsed++;
          if (elapsed >= low_len) begin
            seq     = SEQ_PULL_HIGH;
            elapsed = '0;
          end
        end
        SEQ_PULL_HIGH: begin
          elapsed++;
          if (elapsed >= {8'd0, high_len}) begin
            seq     = SEQ_ACK_HIGH;
            elapsed = '0;
          end
        end
        SEQ_ACK_HIGH, SEQ_ACK_LOW, SEQ_BIT_WAIT: begin
          want = (seq != SEQ_ACK_LOW);
          if (line == want) begin
            seq = (seq == SEQ_ACK_HIGH) ? SEQ_ACK_LOW :
                  (seq == SEQ_ACK_LOW)  ? SEQ_BIT_WAIT : SEQ_BIT_TIME;
            elapsed = '0;
          end else if (elapsed >= wait_limit) begin
            finished = 1'b1;
            failed   = 1'b1;
          end else begin
            elapsed++;
          end
        end
        SEQ_BIT_TIME: begin
          pulse = {1'b0, elapsed} + 1'b1;
          if (!line) begin
            frame_bits = {frame_bits[FRAME_BITS-2:0], pulse > one_limit};
            bits_taken++;
            elapsed = '0;
            if (bits_taken >= FRAME_BITS) begin
              hum_q    = frame_bits[39:32];
              temp_q   = frame_bits[23:16];
              byte_sum = {1'b0, hum_q} + {1'b0, temp_q};
              finished = 1'b1;
              // checksum compares against the sum without wrapping
              if ({1'b0, frame_bits[7:0]} != byte_sum) failed = 1'b1;
              else hold_high = 1'b1;
            end else begin
              seq = SEQ_BIT_WAIT;
            end
          end else if (elapsed >= wait_limit) begin
            finished = 1'b1;
            failed   = 1'b1;
          end else begin
            elapsed++;
          end
        end
        default: begin
          seq = SEQ_IDLE;
          if (start) begin
            seq        = SEQ_PULL_LOW;
            elapsed    = '0;
            bits_taken = '0;
            frame_bits = '0;
            hold_high  = 1'b0;
          end
        end
      endcase

      if (finished) begin
        seq     = SEQ_IDLE;
        elapsed = '0;
        if (failed) hold_high = 1'b0;
      end

      r              = '0;
      r.busy_res     = (seq != SEQ_IDLE);
      r.drive_level  = (seq == SEQ_PULL_HIGH) || (seq == SEQ_IDLE && hold_high);
      r.drive_enable = r.drive_level || (seq == SEQ_PULL_LOW);
      r.done_res     = finished;
      r.status       = finished && failed;
      r.humidity     = hum_q;
      r.temperature  = temp_q;
      due_results.push_back(r);
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= 40)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void compare_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        failures++;
        if (failures <= 40)
          $display("%0t: result transaction with nothing expected, expected none, actual %0h",
                   $time, got);
        return;
      end
      want = due_results.pop_front();
      field_check("drive_enable", want.drive_enable, got.drive_enable);
      field_check("drive_level", want.drive_level, got.drive_level);
      field_check("busy", want.busy_res, got.busy_res);
      field_check("done", want.done_res, got.done_res);
      field_check("status", want.status, got.status);
      field_check("humidity", want.humidity, got.humidity);
      field_check("temperature", want.temperature, got.temperature);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // [0] start_request, [1] line_level, [7:2] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [0] drive_enable, [1] drive_level, [2] busy_res, [3] done_res, [4] status,
  // [12:5] humidity, [20:13] temperature, [23:21] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  reader_tracker tracker = new();
  int            send_gap_pct = 0;
  int            take_gap_pct = 0;
  bit            hold_output = 1'b0;
  int            ticks_sent = 0;

  single_wire_humidity_sensor_reader uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.compare_result(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
  end

  // result side: random back-pressure plus one long hold when asked
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_output = 1'b0;
      end
      m_axis_tready = ($urandom_range(0, 99) >= take_gap_pct);
    end
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_tick(input bit start, input bit line);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(IN_DATA_W - 2){1'b0}}, line, start};
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    tracker.advance_tick(start, line);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tracker.set_register(idx, data);
  endtask

  // 8-bit registers get junk in the upper byte, which must be dropped
  task automatic apply_settings(input logic [15:0] low, input logic [7:0] rel,
                                input logic [7:0] thr, input logic [15:0] tmo);
    wait_drained();
    write_reg(CFG_START_LOW, low);
    write_reg(CFG_RELEASE_HIGH, {8'($urandom), rel});
    write_reg(CFG_ONE_THRESH, {8'($urandom), thr});
    write_reg(CFG_WAIT_TIMEOUT, tmo);
  endtask

  // Plays one reading. The sensor answer is prebuilt as line levels and fed
  // only while the block is listening; pull phases get random line noise.
  task automatic run_reading(input shape_e shape, input logic [FRAME_BITS-1:0] frame);
    bit     levels[$];
    int     wl;
    int     th;
    int     run;
    int     cut_bit;
    stall_e stall_at;
    bit     line;
    wl       = tracker.wait_limit;
    th       = tracker.one_limit;
    cut_bit  = $urandom_range(0, FRAME_BITS - 1);
    stall_at = (shape == SHAPE_STALL) ? stall_e'($urandom_range(0, 3)) : STALL_NONE;
    if (shape != SHAPE_NOISE) begin
      if (stall_at == STALL_ACK_HIGH) begin
        repeat (wl + 1) levels.push_back(1'b0);
      end else begin
        repeat ($urandom_range(0, (wl < 3) ? wl : 3)) levels.push_back(1'b0);
        if (stall_at == STALL_ACK_LOW) begin
          repeat (wl + 2) levels.push_back(1'b1);
        end else begin
          repeat ($urandom_range(1, ((wl < 3) ? wl : 3) + 1)) levels.push_back(1'b1);
          for (int i = 0; i < FRAME_BITS; i++) begin
            if (stall_at == STALL_BIT_GAP && i == cut_bit) begin
              repeat (wl + 2) levels.push_back(1'b0);
              break;
            end
            repeat ($urandom_range(1, ((wl < 1) ? wl : 1) + 1)) levels.push_back(1'b0);
            if (stall_at == STALL_BIT_PULSE && i == cut_bit) begin
              repeat (wl + 2) levels.push_back(1'b1);
              break;
            end
            // pulse length sits right at the decision edge
            if (frame[FRAME_BITS - 1 - i])
              run = th + 1 + ((th + 3 <= wl) ? $urandom_range(0, 2) : 0);
            else
              run = (th == 0) ? 1 : th - $urandom_range(0, (th - 1 < 2) ? th - 1 : 2);
            repeat (run) levels.push_back(1'b1);
          end
          if (stall_at == STALL_NONE) levels.push_back(1'b0);
        end
      end
    end

    repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom));
    send_tick(1'b1, 1'($urandom));
    while (tracker.busy()) begin
      if (tracker.answering() && levels.size() != 0) line = levels.pop_front();
      else line = 1'($urandom);
      // start while busy must be ignored
      send_tick($urandom_range(0, 15) == 0, line);
    end
  endtask

  task automatic random_stretch(input int min_ticks, input int min_readings, input bit squeeze);
    int              first_tick;
    int              readings;
    int              pick;
    logic [7:0]      thr;
    logic [7:0]      b0;
    logic [7:0]      b2;
    logic [7:0]      b4;
    shape_e          shape;
    first_tick = ticks_sent;
    readings   = 0;
    while (ticks_sent - first_tick < min_ticks || readings < min_readings) begin
      thr = $urandom_range(0, 2);
      apply_settings($urandom_range(0, 6), $urandom_range(0, 6), thr,
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6)
                                                 : thr + $urandom_range(0, 6));
      pick  = $urandom_range(0, 99);
      shape = SHAPE_FRAME;
      b0    = 8'($urandom);
      b2    = 8'($urandom_range(0, 255 - b0));
      b4    = b0 + b2;
      if (pick >= 60 && pick < 75) begin
        if ($urandom_range(0, 2) == 0) begin
          // sum overflows a byte, low byte matches: still a checksum error
          b0 = 8'($urandom_range(129, 255));
          b2 = 8'($urandom_range(256 - b0, 255));
          b4 = b0 + b2;
        end else begin
          b2 = 8'($urandom);
          b4 = 8'($urandom);
          if ({1'b0, b4} == {1'b0, b0} + {1'b0, b2}) b4 = b4 ^ 8'd1;
        end
      end else if (pick >= 75 && pick < 90) begin
        shape = SHAPE_STALL;
      end else if (pick >= 90) begin
        shape = SHAPE_NOISE;
      end
      if (squeeze && readings == 0) hold_output = 1'b1;
      run_reading(shape, {b0, 8'($urandom), b2, 8'($urandom), b4});
      readings++;
      if (squeeze && readings == 1) wait_drained();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_START_LOW;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_gap_pct = 35;
    take_gap_pct = 80;

    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    // power-on register values: the line stays pulled low well past these ticks
    send_tick(1'b1, 1'b1);
    repeat (20) send_tick(1'b0, 1'($urandom));
    // widest values while still pulling low, then short ones to end the reading
    apply_settings(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
    repeat (10) send_tick(1'b0, 1'($urandom));
    apply_settings(16'd2, 8'd1, 8'd1, 16'd2);
    while (tracker.busy()) send_tick($urandom_range(0, 15) == 0, 1'($urandom));

    // all-zero settings: every pulse decodes as one, single-mismatch timeout
    apply_settings(16'd0, 8'd0, 8'd0, 16'd0);
    run_reading(SHAPE_FRAME, {8'h12, 8'h34, 8'h56, 8'h78, 8'h68});
    run_reading(SHAPE_STALL, '0);

    apply_settings(16'd3, 8'd2, 8'd1, 16'd6);
    // byte sum overflows while its low byte matches
    run_reading(SHAPE_FRAME, {8'd200, 8'h00, 8'd100, 8'h00, 8'd44});

    random_stretch(0, 1, 1'b0);
    send_gap_pct = 80;
    take_gap_pct = 35;
    random_stretch(0, 1, 1'b0);
    send_gap_pct = 0;
    take_gap_pct = 0;
    random_stretch(0, 1, 1'b1);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
